// ----- design/digram_text_decompressor_macros.svh -----
// assertion macros for the checker of the digram text decompressor
`ifndef DIGRAM_TEXT_DECOMPRESSOR_MACROS_SVH
`define DIGRAM_TEXT_DECOMPRESSOR_MACROS_SVH

// consequent checked in the same cycle
`define DTD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("digram text decompressor check failed");

// consequent checked in the next cycle
`define DTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("digram text decompressor check failed");

`endif

// ----- design/dtd_pkg.sv -----
package dtd_pkg;

    localparam int DIGRAM_SIZE = 144;

    localparam logic [7:0]  ESC_BYTE         = 8'h1B;
    localparam logic [7:0]  ESC_BIAS         = 8'h7F;
    localparam logic [7:0]  END_BYTE         = 8'h00;
    localparam logic [7:0]  PAIR_OFFSET      = 8'd16;
    localparam logic [15:0] MAX_LENGTH_RESET = 16'd1024;
    localparam logic [15:0] MIN_LENGTH       = 16'd2;

    // first character of the string sits in the top byte
    localparam logic [DIGRAM_SIZE*8-1:0] DIGRAM_TEXT = {
        " etainosrlhcdupm",
        "tasio wb", " rnsdalm", "h ieoras", "nrtlc sy",
        "nstcloer", " dtgesio", "nr ufmsw", " tep.ica",
        "e oiadur", " laeiyod", "eia otru", "etoakhlr",
        " eiu,.oa", "nsrctlai", "leoiratp", "eaoip bm"
    };

    typedef struct packed {
        logic [7:0]  out_char;
        logic        char_valid;
        logic        is_last;
        logic [15:0] length;
    } dtd_res_t;

    function automatic logic [7:0] digram_char(input logic [7:0] idx);
        return DIGRAM_TEXT[(DIGRAM_SIZE - 1 - int'(idx)) * 8 +: 8];
    endfunction

endpackage

// ----- design/dtd_if.sv -----
interface dtd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface dtd_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_char;
    logic        char_valid;
    logic        is_last;
    logic [15:0] length;

    modport source (output valid, output out_char, output char_valid, output is_last,
                    output length, input ready);
    modport sink   (input valid, input out_char, input char_valid, input is_last,
                    input length, output ready);
endinterface

interface dtd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_length;

    modport source (output valid, output max_length, input ready);
    modport sink   (input valid, input max_length, output ready);
endinterface

// ----- design/digram_text_decompressor.sv -----
// Digram text decompressor: takes one compressed byte per transaction on code_ch and
// delivers decoded characters, one per transaction, on text_ch; a zero byte closes the
// string with an end marker (char_valid low, is_last high) that carries the length, unless
// the length cap closed it first. An accepted byte is registered, decoded once the queue
// holds at most two results, and its zero, one or two results are pushed into a
// four-entry result queue; text_ch shows the queue head. A byte that gives at most one
// result can be taken every cycle while text_ch is ready; a pair byte backs up the queue,
// since text_ch delivers one result per cycle. First result reaches text_ch through
// in_byte_reg and the queue and can be taken at the following edge. cfg_ch is always
// ready and max_length should be written while no string is in flight.
module digram_text_decompressor (
    input  logic       clk,
    input  logic       rst_n,
    dtd_byte_if.sink   code_ch,
    dtd_res_if.source  text_ch,
    dtd_cfg_if.sink    cfg_ch
);
    import dtd_pkg::*;

    localparam logic [2:0] FILL_LIMIT = 3'd2;

    logic [15:0] max_length_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    logic        esc_reg, esc_next;
    logic        disc_reg, disc_next;
    logic [15:0] count_reg, count_next;

    dtd_res_t    queue_reg [0:3];
    logic [1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [2:0]  fill_reg;

    dtd_res_t    res0, res1;
    logic [1:0]  n_push;
    logic        fire, pop;

    logic [15:0] cap, cnt1, cnt2;
    logic        at_cap1, at_cap2;

    assign fire         = in_valid_reg && (fill_reg <= FILL_LIMIT);
    assign pop          = (fill_reg != 3'd0) && text_ch.ready;
    assign code_ch.ready = !in_valid_reg || fire;
    assign cfg_ch.ready  = 1'b1;

    assign cap     = (max_length_reg >= MIN_LENGTH) ? max_length_reg - 16'd1 : 16'd1;
    assign cnt1    = count_reg + 16'd1;
    assign cnt2    = count_reg + 16'd2;
    assign at_cap1 = cnt1 >= cap;
    assign at_cap2 = cnt2 >= cap;

    always_comb
    begin
        logic [7:0] b;
        b          = in_byte_reg;
        res0       = '0;
        res1       = '0;
        n_push     = 2'd0;
        esc_next   = esc_reg;
        disc_next  = disc_reg;
        count_next = count_reg;

        if (disc_reg)
        begin
            if (b == END_BYTE)
            begin
                disc_next  = 1'b0;
                esc_next   = 1'b0;
                count_next = 16'd0;
            end
        end
        else if (esc_reg)
        begin
            esc_next = 1'b0;
            res0     = '{out_char: ESC_BIAS + b, char_valid: 1'b1, is_last: at_cap1,
                         length: cnt1};
            n_push   = 2'd1;
            if (b == END_BYTE)
            begin
                // escape then zero: 0x7f, then an end marker unless it already hit the cap
                count_next = 16'd0;
                if (!at_cap1)
                begin
                    res1   = '{out_char: 8'd0, char_valid: 1'b0, is_last: 1'b1, length: cnt1};
                    n_push = 2'd2;
                end
            end
            else
            begin
                count_next = cnt1;
                disc_next  = at_cap1;
            end
        end
        else if (b == END_BYTE)
        begin
            res0       = '{out_char: 8'd0, char_valid: 1'b0, is_last: 1'b1, length: count_reg};
            n_push     = 2'd1;
            count_next = 16'd0;
        end
        else if (b[7])
        begin
            res0 = '{out_char: digram_char({4'd0, b[6:3]}), char_valid: 1'b1,
                     is_last: at_cap1, length: cnt1};
            if (at_cap1)
            begin
                n_push     = 2'd1;
                count_next = cnt1;
                disc_next  = 1'b1;
            end
            else
            begin
                res1 = '{out_char: digram_char({1'b0, b[6:0]} + PAIR_OFFSET),
                         char_valid: 1'b1, is_last: at_cap2, length: cnt2};
                n_push     = 2'd2;
                count_next = cnt2;
                disc_next  = at_cap2;
            end
        end
        else if (b == ESC_BYTE)
        begin
            esc_next = 1'b1;
        end
        else
        begin
            res0       = '{out_char: b, char_valid: 1'b1, is_last: at_cap1, length: cnt1};
            n_push     = 2'd1;
            count_next = cnt1;
            disc_next  = at_cap1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RESET;
            in_valid_reg   <= 1'b0;
            esc_reg        <= 1'b0;
            disc_reg       <= 1'b0;
            count_reg      <= 16'd0;
            wr_ptr_reg     <= 2'd0;
            rd_ptr_reg     <= 2'd0;
            fill_reg       <= 3'd0;
        end
        else
        begin
            if (cfg_ch.valid)
            begin
                max_length_reg <= cfg_ch.max_length;
            end
            if (code_ch.valid && code_ch.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                esc_reg    <= esc_next;
                disc_reg   <= disc_next;
                count_reg  <= count_next;
                wr_ptr_reg <= wr_ptr_reg + n_push;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            fill_reg <= fill_reg + (fire ? {1'b0, n_push} : 3'd0) - {2'd0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (code_ch.valid && code_ch.ready)
        begin
            in_byte_reg <= code_ch.in_byte;
        end
        if (fire && (n_push != 2'd0))
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (fire && (n_push == 2'd2))
        begin
            queue_reg[wr_ptr_reg + 2'd1] <= res1;
        end
    end

    assign text_ch.valid      = (fill_reg != 3'd0);
    assign text_ch.out_char   = queue_reg[rd_ptr_reg].out_char;
    assign text_ch.char_valid = queue_reg[rd_ptr_reg].char_valid;
    assign text_ch.is_last    = queue_reg[rd_ptr_reg].is_last;
    assign text_ch.length     = queue_reg[rd_ptr_reg].length;

endmodule

// ----- design/dtd_checker.sv -----
`include "digram_text_decompressor_macros.svh"

module dtd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_char,
    input logic        char_valid,
    input logic        is_last,
    input logic [15:0] length
);
    logic        xfer;
    logic        done_reg;
    logic [15:0] len_reg;

    assign xfer = out_valid && out_ready;

    // remembers whether the previous transaction closed a string and its length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b1;
            len_reg  <= 16'd0;
        end
        else if (xfer)
        begin
            done_reg <= is_last;
            len_reg  <= length;
        end
    end

    `DTD_ASSERT_NEXT(a_valid_holds, out_valid && !out_ready, out_valid)
    `DTD_ASSERT_NEXT(a_payload_holds, out_valid && !out_ready,
        $stable(out_char) && $stable(char_valid) && $stable(is_last) && $stable(length))
    `DTD_ASSERT_NOW(a_char_length_steps, xfer && char_valid,
        length == (done_reg ? 16'd1 : len_reg + 16'd1))
    `DTD_ASSERT_NOW(a_end_marker_length, xfer && !char_valid,
        is_last && (length == (done_reg ? 16'd0 : len_reg)))

endmodule

bind digram_text_decompressor dtd_checker u_dtd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (text_ch.valid),
    .out_ready  (text_ch.ready),
    .out_char   (text_ch.out_char),
    .char_valid (text_ch.char_valid),
    .is_last    (text_ch.is_last),
    .length     (text_ch.length)
);

// ----- test/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dtd_pkg::*;

    typedef enum bit {ROW_BYTE, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [15:0] value;
        int          typed;
        dtd_res_t    r0;
        dtd_res_t    r1;
    } stim_row_t;

    localparam int       PREDICT = -1;
    localparam dtd_res_t NO_RES  = '0;

    // first character of the pair table sits at index 0
    localparam logic [0:143][7:0] PAIR_TABLE = {
        " etainosrlhcdupm",
        "tasio wb", " rnsdalm", "h ieoras", "nrtlc sy",
        "nstcloer", " dtgesio", "nr ufmsw", " tep.ica",
        "e oiadur", " laeiyod", "eia otru", "etoakhlr",
        " eiu,.oa", "nsrctlai", "leoiratp", "eaoip bm"
    };

    logic clk = 1'b0;
    logic rst_n;

    dtd_byte_if code_ch ();
    dtd_res_if  text_ch ();
    dtd_cfg_if  cfg_ch ();

    digram_text_decompressor dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .code_ch (code_ch),
        .text_ch (text_ch),
        .cfg_ch  (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // decoder state as seen from the ports
    logic [15:0] model_max   = MAX_LENGTH_RESET;
    logic [15:0] model_count = '0;
    bit          model_esc   = 1'b0;
    bit          model_drop  = 1'b0;

    dtd_res_t pending_text[$];

    int  errors       = 0;
    int  bytes_sent   = 0;
    int  results_seen = 0;
    int  strings_done = 0;
    int  cap_hits     = 0;
    int  cfg_writes   = 0;
    bit  sender_gaps  = 1'b1;
    bit  sink_stalls  = 1'b1;

    task automatic report(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        errors++;
    endtask

    function automatic bit put_char(input logic [7:0] ch);
        logic [15:0] cap;
        logic [15:0] cnt;
        bit          last;
        cap = (model_max >= MIN_LENGTH) ? model_max - 16'd1 : 16'd1;
        cnt = model_count + 16'd1;
        last = (cnt >= cap);
        model_count = cnt;
        pending_text.push_back('{ch, 1'b1, last, cnt});
        if (last)
            model_drop = 1'b1;
        return last;
    endfunction

    function automatic void put_end();
        pending_text.push_back('{8'h00, 1'b0, 1'b1, model_count});
        model_count = '0;
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        int c;
        c = int'(b[6:0]);
        if (model_drop)
        begin
            if (b == END_BYTE)
            begin
                model_drop = 1'b0;
                model_esc = 1'b0;
                model_count = '0;
            end
        end
        else if (model_esc)
        begin
            model_esc = 1'b0;
            if (b == END_BYTE)
            begin
                // escaped zero: 0x7f then the end marker unless 0x7f closed it
                if (put_char(ESC_BIAS))
                begin
                    model_drop = 1'b0;
                    model_count = '0;
                end
                else
                    put_end();
            end
            else
                void'(put_char(ESC_BIAS + b));
        end
        else if (b == END_BYTE)
            put_end();
        else if (b[7])
        begin
            if (!put_char(PAIR_TABLE[c >> 3]))
                void'(put_char(PAIR_TABLE[c + int'(PAIR_OFFSET)]));
        end
        else if (b == ESC_BYTE)
            model_esc = 1'b1;
        else
            void'(put_char(b));
    endfunction

    task automatic send_byte(input logic [7:0] b, output int added);
        int gap;
        int n0;
        gap = sender_gaps ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            code_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        code_ch.valid <= 1'b1;
        code_ch.in_byte <= b;
        @(negedge clk);
        while (!code_ch.ready)
            @(negedge clk);
        @(posedge clk);
        n0 = pending_text.size();
        decode_byte(b);
        added = pending_text.size() - n0;
        bytes_sent++;
    endtask

    // sender goes quiet until every expected result is back
    task automatic settle();
        code_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_text.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_max_length(input logic [15:0] v);
        settle();
        repeat (8) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.max_length <= v;
        @(negedge clk);
        while (!cfg_ch.ready)
            @(negedge clk);
        @(posedge clk);
        cfg_ch.valid <= 1'b0;
        model_max = v;
        cfg_writes++;
    endtask

    task automatic send_string();
        int         n;
        int         i;
        int         kind;
        int         added;
        bit         closed;
        logic [7:0] b;
        n = $urandom_range(0, 14);
        closed = 1'b0;
        for (i = 0; i < n; i++)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 3)
                send_byte(8'($urandom_range(1, 127)), added);
            else if (kind <= 6)
                send_byte(8'($urandom_range(128, 255)), added);
            else if (kind == 7)
            begin
                send_byte(ESC_BYTE, added);
                b = ($urandom_range(0, 4) == 0) ? END_BYTE : 8'($urandom_range(0, 255));
                send_byte(b, added);
                if (b == END_BYTE)
                begin
                    closed = 1'b1;
                    break;
                end
            end
            else if (kind == 8)
                send_byte(8'($urandom_range(0, 255)), added);
            else
                // lone escape, the next token gets swallowed by it
                send_byte(ESC_BYTE, added);
        end
        if (!closed || $urandom_range(0, 3) == 0)
            send_byte(END_BYTE, added);
    endtask

    // result side
    initial
    begin
        int       stall;
        dtd_res_t got;
        dtd_res_t want;
        text_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = sink_stalls ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                text_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            text_ch.ready <= 1'b1;
            @(negedge clk);
            while (!text_ch.valid)
                @(negedge clk);
            got = '{text_ch.out_char, text_ch.char_valid, text_ch.is_last, text_ch.length};
            @(posedge clk);
            results_seen++;
            if (pending_text.size() == 0)
                report($sformatf("unexpected result char %02h valid %0b last %0b length %0d",
                                 got.out_char, got.char_valid, got.is_last, got.length));
            else
            begin
                want = pending_text.pop_front();
                if (got.out_char !== want.out_char)
                    report($sformatf("out_char %02h, wanted %02h", got.out_char, want.out_char));
                if (got.char_valid !== want.char_valid)
                    report($sformatf("char_valid %0b, wanted %0b",
                                     got.char_valid, want.char_valid));
                if (got.is_last !== want.is_last)
                    report($sformatf("is_last %0b, wanted %0b", got.is_last, want.is_last));
                if (got.length !== want.length)
                    report($sformatf("length %0d, wanted %0d", got.length, want.length));
                if (want.is_last)
                    strings_done++;
                if (want.is_last && want.char_valid)
                    cap_hits++;
            end
        end
    end

    initial
    begin
        stim_row_t   dir_rows[$];
        int          added;
        int          k;
        int          p;
        int          start;
        logic [15:0] cap;

        code_ch.valid <= 1'b0;
        code_ch.in_byte <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.max_length <= MAX_LENGTH_RESET;
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_rows = '{
            '{ROW_BYTE, 16'(END_BYTE), 1, '{8'h00, 1'b0, 1'b1, 16'd0}, NO_RES},
            '{ROW_BYTE, 16'h0041, 1, '{8'h41, 1'b1, 1'b0, 16'd1}, NO_RES},
            '{ROW_BYTE, 16'h00ff, PREDICT, NO_RES, NO_RES},
            '{ROW_BYTE, 16'h0080, PREDICT, NO_RES, NO_RES},
            '{ROW_BYTE, 16'(ESC_BYTE), 0, NO_RES, NO_RES},
            '{ROW_BYTE, 16'h00ff, PREDICT, NO_RES, NO_RES},
            '{ROW_BYTE, 16'(ESC_BYTE), PREDICT, NO_RES, NO_RES},
            '{ROW_BYTE, 16'(END_BYTE), PREDICT, NO_RES, NO_RES},
            '{ROW_BYTE, 16'h007f, PREDICT, NO_RES, NO_RES},
            '{ROW_BYTE, 16'(ESC_BYTE), PREDICT, NO_RES, NO_RES},
            '{ROW_BYTE, 16'(ESC_BYTE), PREDICT, NO_RES, NO_RES},
            '{ROW_BYTE, 16'h0001, PREDICT, NO_RES, NO_RES},
            '{ROW_BYTE, 16'(END_BYTE), PREDICT, NO_RES, NO_RES},
            // cap of two characters
            '{ROW_CFG,  16'd3,    PREDICT, NO_RES, NO_RES},
            '{ROW_BYTE, 16'h0061, PREDICT, NO_RES, NO_RES},
            '{ROW_BYTE, 16'h0062, PREDICT, NO_RES, NO_RES},
            '{ROW_BYTE, 16'h0063, PREDICT, NO_RES, NO_RES},
            '{ROW_BYTE, 16'(END_BYTE), PREDICT, NO_RES, NO_RES},
            '{ROW_BYTE, 16'h0061, PREDICT, NO_RES, NO_RES},
            '{ROW_BYTE, 16'h0085, PREDICT, NO_RES, NO_RES},
            '{ROW_BYTE, 16'(END_BYTE), PREDICT, NO_RES, NO_RES},
            '{ROW_BYTE, 16'h0061, PREDICT, NO_RES, NO_RES},
            '{ROW_BYTE, 16'(ESC_BYTE), PREDICT, NO_RES, NO_RES},
            '{ROW_BYTE, 16'(END_BYTE), PREDICT, NO_RES, NO_RES},
            // cap of one character, pair is clipped
            '{ROW_CFG,  MIN_LENGTH, PREDICT, NO_RES, NO_RES},
            '{ROW_BYTE, 16'h0090, 1, '{8'h74, 1'b1, 1'b1, 16'd1}, NO_RES},
            '{ROW_BYTE, 16'(END_BYTE), 0, NO_RES, NO_RES},
            // cap lowered in the middle of a string
            '{ROW_CFG,  16'hffff, PREDICT, NO_RES, NO_RES},
            '{ROW_BYTE, 16'h0041, PREDICT, NO_RES, NO_RES},
            '{ROW_BYTE, 16'h0042, PREDICT, NO_RES, NO_RES},
            '{ROW_CFG,  16'd4,    PREDICT, NO_RES, NO_RES},
            '{ROW_BYTE, 16'h0043, PREDICT, NO_RES, NO_RES},
            '{ROW_BYTE, 16'(END_BYTE), PREDICT, NO_RES, NO_RES},
            '{ROW_CFG,  MAX_LENGTH_RESET, PREDICT, NO_RES, NO_RES}
        };

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_max_length(dir_rows[i].value);
            else
            begin
                send_byte(dir_rows[i].value[7:0], added);
                if (dir_rows[i].typed != PREDICT)
                begin
                    // the typed row replaces what the predictor just queued
                    for (k = 0; k < added; k++)
                        void'(pending_text.pop_back());
                    if (dir_rows[i].typed > 0)
                        pending_text.push_back(dir_rows[i].r0);
                    if (dir_rows[i].typed > 1)
                        pending_text.push_back(dir_rows[i].r1);
                end
            end
        end

        for (p = 0; p < 9; p++)
        begin
            case (p)
                0: cap = MIN_LENGTH;
                1: cap = 16'hffff;
                2: cap = MAX_LENGTH_RESET;
                default: cap = 16'($urandom_range(3, 30));
            endcase
            // every third phase runs both sides flat out
            sender_gaps = (p % 3 != 1);
            sink_stalls = (p % 3 != 1);
            write_max_length(cap);
            start = bytes_sent;
            while (bytes_sent - start < 45)
            begin
                send_string();
                if (p == 4 && bytes_sent - start < 20)
                    settle();
            end
        end

        settle();
        repeat (10) @(posedge clk);
        $display("sent %0d bytes over %0d max_length settings, checked %0d results",
                 bytes_sent, cfg_writes, results_seen);
        $display("%0d strings closed, %0d of them at the length cap", strings_done, cap_hits);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        #1ms;
        $display("timeout waiting for the decompressor");
        $display("testbench NOT OK");
        $finish;
    end

endmodule
